FILE: rtl/isq_pkg.sv
// Package for the indexed sorted priority queue: constants, codes and the cell control struct.
package isq_pkg;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF    = 16;
  localparam int IDX_BITS        = 6;
  localparam int IN_KEY_BITS     = 16;
  localparam int CNT_BITS        = 7;
  localparam int ERR_BITS        = 3;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_POP    = 2'd1;
  localparam logic [1:0] FN_CHANGE = 2'd2;
  localparam logic [1:0] FN_DELETE = 2'd3;

  localparam logic [ERR_BITS-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_BITS-1:0] ERR_FULL    = 3'd1;
  localparam logic [ERR_BITS-1:0] ERR_EMPTY   = 3'd2;
  localparam logic [ERR_BITS-1:0] ERR_ABSENT  = 3'd3;
  localparam logic [ERR_BITS-1:0] ERR_PRESENT = 3'd4;

  // Broadcast command to every cell.
  typedef struct packed {
    logic                remove;  // take the entry with idx out, close the gap
    logic                insert;  // place idx/key at its sorted position
    logic                tie;     // on insert, equal keys behind the last removed slot go behind
    logic                pop;     // drop the tail entry
    logic [IDX_BITS-1:0] idx;
  } cell_cmd_t;
endpackage

FILE: rtl/isq_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module isq_cell #(
  parameter int KEY_BITS = isq_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  isq_pkg::cell_cmd_t          cmd,
  input  logic [KEY_BITS-1:0]         new_key,
  // Neighbor toward the front (lower position); prev_hit means a hit at or before it.
  input  logic                        prev_valid,
  input  logic                        prev_hit,
  input  logic                        prev_gt,
  input  logic [isq_pkg::IDX_BITS-1:0] prev_idx,
  input  logic [KEY_BITS-1:0]         prev_key,
  // Neighbor toward the tail.
  input  logic                        next_valid,
  input  logic                        next_hit,
  input  logic [isq_pkg::IDX_BITS-1:0] next_idx,
  input  logic [KEY_BITS-1:0]         next_key,
  input  logic                        is_tail,
  output logic                        valid,
  output logic                        hit,
  output logic                        gt,
  output logic [isq_pkg::IDX_BITS-1:0] idx,
  output logic [KEY_BITS-1:0]         key
);
  logic                         valid_r, valid_nxt;
  logic                         moved_r, moved_nxt;
  logic [isq_pkg::IDX_BITS-1:0] idx_r, idx_nxt;
  logic [KEY_BITS-1:0]          key_r, key_nxt;

  assign valid = valid_r;
  assign idx   = idx_r;
  assign key   = key_r;
  assign hit   = valid_r && (idx_r == cmd.idx);
  // The new entry goes in front of this one: its key is strictly greater, or equal while
  // this cell lies at or behind the slot freed by the last remove.
  assign gt    = valid_r && ((key_r > new_key) ||
                             (cmd.tie && moved_r && (key_r == new_key)));

  always_comb begin
    valid_nxt = valid_r;
    moved_nxt = moved_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    if (cmd.remove) begin
      // Cells at or behind the removed entry take their back neighbor.
      moved_nxt = hit || prev_hit;
      if (hit || prev_hit) begin
        valid_nxt = next_valid && !next_hit;
        idx_nxt   = next_idx;
        key_nxt   = next_key;
      end
    end else if (cmd.pop) begin
      if (is_tail) valid_nxt = 1'b0;
    end else if (cmd.insert) begin
      if (prev_gt) begin
        valid_nxt = prev_valid;
        idx_nxt   = prev_idx;
        key_nxt   = prev_key;
      end else if (prev_valid && (gt || !valid_r)) begin
        valid_nxt = 1'b1;
        idx_nxt   = cmd.idx;
        key_nxt   = new_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    moved_r <= moved_nxt;
    idx_r   <= idx_nxt;
    key_r   <= key_nxt;
  end
endmodule

FILE: rtl/indexed_sorted_priority_queue.sv
// Top level of the indexed sorted priority queue: control sequencer and the chain of cells.
// The result strobes in the DONE state: insert, remove maximum and any error go from EXEC
// straight to DONE, change key passes through INS, and a delete that leaves entries passes
// through LIFT and INS; busy is high through the strobe, so a new transaction waits for idle.
// Each step is one broadcast to the cell chain, for any queue length; change key is a remove
// step and an insert step, and delete also lifts the tail entry out and inserts it again.
// Reset: rst_n synchronous, active low, empties the queue; the receiver cannot stall.
module indexed_sorted_priority_queue #(
  parameter int MAX_ENTRIES = isq_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = isq_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [isq_pkg::IDX_BITS-1:0]  in_item_index,
  input  logic [isq_pkg::IN_KEY_BITS-1:0] in_item_key,
  output logic                          out_strobe,
  output logic [isq_pkg::IDX_BITS-1:0]  out_popped_index,
  output logic                          out_popped_valid,
  output logic [isq_pkg::CNT_BITS-1:0]  out_queue_count,
  output logic                          out_queue_empty,
  output logic [isq_pkg::ERR_BITS-1:0]  out_error_code
);
  // The index space is 64, so the chain never holds more than that.
  localparam int CAP = (MAX_ENTRIES < 64) ? MAX_ENTRIES : 64;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_LIFT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0]                   func_r;
  logic [isq_pkg::IDX_BITS-1:0] idx_r;
  logic [KEY_BITS-1:0]          key_r;
  logic [isq_pkg::CNT_BITS-1:0] count_r, count_nxt;
  logic [63:0]                  present_r, present_nxt;
  logic [isq_pkg::IDX_BITS-1:0] pidx_r, pidx_nxt;
  logic                         pval_r, pval_nxt;
  logic [isq_pkg::ERR_BITS-1:0] err_r, err_nxt;

  isq_pkg::cell_cmd_t cmd;
  logic [CAP-1:0] c_valid, c_hit, c_hit_upto, c_gt, is_tail;
  logic [isq_pkg::IDX_BITS-1:0] c_idx [CAP];
  logic [KEY_BITS-1:0]          c_key [CAP];
  logic [isq_pkg::IDX_BITS-1:0] tail_idx;
  logic [KEY_BITS-1:0]          tail_key;

  logic present_in;
  assign present_in = present_r[idx_r];
  assign busy = (state_r != ST_IDLE);

  // The tail cell is the last valid one; the chain is packed from position zero.
  always_comb begin
    tail_idx = '0;
    tail_key = '0;
    for (int i = 0; i < CAP; i++) begin
      is_tail[i] = c_valid[i] && ((i == CAP-1) ? 1'b1 : !c_valid[(i+1) % CAP]);
      if (is_tail[i]) begin
        tail_idx = c_idx[i];
        tail_key = c_key[i];
      end
    end
  end

  // Hit propagation for the remove shift: every cell at or behind the hit must shift,
  // so each cell sees whether the hit lies at or before its front neighbor.
  always_comb begin
    c_hit_upto[0] = c_hit[0];
    for (int i = 1; i < CAP; i++) c_hit_upto[i] = c_hit_upto[i-1] | c_hit[i];
  end

  // The first cell sees a valid, never greater entry in front of it, so it takes
  // the new entry whenever it is empty or holds a greater key.
  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      isq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .new_key    (key_r),
        .prev_valid ((g == 0) ? 1'b1 : c_valid[(g+CAP-1) % CAP]),
        .prev_hit   ((g == 0) ? 1'b0 : c_hit_upto[(g+CAP-1) % CAP]),
        .prev_gt    ((g == 0) ? 1'b0 : c_gt[(g+CAP-1) % CAP]),
        .prev_idx   (c_idx[(g+CAP-1) % CAP]),
        .prev_key   (c_key[(g+CAP-1) % CAP]),
        .next_valid ((g == CAP-1) ? 1'b0 : c_valid[(g+1) % CAP]),
        .next_hit   ((g == CAP-1) ? 1'b0 : c_hit[(g+1) % CAP]),
        .next_idx   (c_idx[(g+1) % CAP]),
        .next_key   (c_key[(g+1) % CAP]),
        .is_tail    (is_tail[g]),
        .valid      (c_valid[g]),
        .hit        (c_hit[g]),
        .gt         (c_gt[g]),
        .idx        (c_idx[g]),
        .key        (c_key[g])
      );
    end
  endgenerate

  // Change key and the re-insert of a delete place the entry in front of equal keys
  // that lie behind the freed slot, and behind equal keys in front of it.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    present_nxt = present_r;
    pidx_nxt    = pidx_r;
    pval_nxt    = pval_r;
    err_nxt     = err_r;
    cmd         = '0;
    cmd.idx     = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        pidx_nxt  = '0;
        pval_nxt  = 1'b0;
        err_nxt   = isq_pkg::ERR_OK;
        state_nxt = ST_DONE;
        unique case (func_r)
          isq_pkg::FN_INSERT: begin
            if (present_in) begin
              err_nxt = isq_pkg::ERR_PRESENT;
            end else if (count_r >= isq_pkg::CNT_BITS'(CAP)) begin
              err_nxt = isq_pkg::ERR_FULL;
            end else begin
              cmd.insert = 1'b1;
              count_nxt  = count_r + 1'b1;
              present_nxt[idx_r] = 1'b1;
            end
          end
          isq_pkg::FN_POP: begin
            if (count_r == '0) begin
              err_nxt = isq_pkg::ERR_EMPTY;
            end else begin
              cmd.pop   = 1'b1;
              count_nxt = count_r - 1'b1;
              pidx_nxt  = tail_idx;
              pval_nxt  = 1'b1;
              present_nxt[tail_idx] = 1'b0;
            end
          end
          isq_pkg::FN_CHANGE: begin
            if (!present_in) begin
              err_nxt = isq_pkg::ERR_ABSENT;
            end else begin
              cmd.remove = 1'b1;
              state_nxt  = ST_INS;
            end
          end
          default: begin
            if (!present_in) begin
              err_nxt = isq_pkg::ERR_ABSENT;
            end else begin
              cmd.remove = 1'b1;
              count_nxt  = count_r - 1'b1;
              present_nxt[idx_r] = 1'b0;
              // The tail entry takes the freed slot, so it is lifted out and re-inserted.
              if (count_r > isq_pkg::CNT_BITS'(1)) state_nxt = ST_LIFT;
            end
          end
        endcase
      end
      ST_LIFT: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_INS;
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        cmd.tie    = 1'b1;
        state_nxt  = ST_DONE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      present_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      present_r <= present_nxt;
    end
    if (state_r == ST_IDLE && start) begin
      func_r <= in_func;
      idx_r  <= in_item_index;
      key_r  <= KEY_BITS'(in_item_key);
    end else if (state_r == ST_LIFT) begin
      idx_r  <= tail_idx;
      key_r  <= tail_key;
    end
    pidx_r <= pidx_nxt;
    pval_r <= pval_nxt;
    err_r  <= err_nxt;
  end

  assign out_strobe       = (state_r == ST_DONE);
  assign out_popped_index = pidx_r;
  assign out_popped_valid = pval_r;
  assign out_queue_count  = count_r;
  assign out_queue_empty  = (count_r == '0);
  assign out_error_code   = err_r;

  // The number of occupied cells always matches the entry count once settled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(c_valid) == int'(count_r)))
    else $error("cell occupancy differs from entry count");
  // A popped index is no longer present after the pop.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_popped_valid) |-> !present_r[out_popped_index])
    else $error("popped index still marked present");
  // An error leaves the count unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && err_nxt != isq_pkg::ERR_OK) |=> $stable(count_r))
    else $error("count changed on an error");
endmodule

FILE: dv/indexed_sorted_priority_queue_tb.sv
// Self-checking testbench for the indexed sorted priority queue: directed and random traffic.
`timescale 1ns / 1ps

module indexed_sorted_priority_queue_tb;
  localparam int CAPACITY    = 64;
  localparam int WATCHDOG    = 5000;
  localparam int DRAIN_WAIT  = 10;

  // One command transaction as the driver applies it.
  typedef struct packed {
    logic [1:0]                      func;
    logic [isq_pkg::IDX_BITS-1:0]    index;
    logic [isq_pkg::IN_KEY_BITS-1:0] key;
  } cmd_t;

  // One response transaction as the block reports it.
  typedef struct packed {
    logic [isq_pkg::IDX_BITS-1:0] popped_index;
    logic                         popped_valid;
    logic [isq_pkg::CNT_BITS-1:0] queue_count;
    logic                         queue_empty;
    logic [isq_pkg::ERR_BITS-1:0] error_code;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = isq_pkg::FN_INSERT;
  logic [isq_pkg::IDX_BITS-1:0] in_item_index = '0;
  logic [isq_pkg::IN_KEY_BITS-1:0] in_item_key = '0;
  logic out_strobe;
  logic [isq_pkg::IDX_BITS-1:0] out_popped_index;
  logic out_popped_valid;
  logic [isq_pkg::CNT_BITS-1:0] out_queue_count;
  logic out_queue_empty;
  logic [isq_pkg::ERR_BITS-1:0] out_error_code;

  indexed_sorted_priority_queue DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_item_index(in_item_index), .in_item_key(in_item_key),
    .out_strobe(out_strobe), .out_popped_index(out_popped_index),
    .out_popped_valid(out_popped_valid), .out_queue_count(out_queue_count),
    .out_queue_empty(out_queue_empty), .out_error_code(out_error_code)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue: sorted slots hold indices, keys live per index.
  logic [isq_pkg::IDX_BITS-1:0]    slot_idx [CAPACITY];
  logic [isq_pkg::IDX_BITS-1:0]    where_is [CAPACITY];
  logic [isq_pkg::IN_KEY_BITS-1:0] key_of   [CAPACITY];
  logic [CAPACITY-1:0]             in_queue = '0;
  int                              depth = 0;

  cmd_t  pending_cmds[$];
  resp_t expected_resps[$];
  int    mismatches = 0;
  int    responses_seen = 0;
  int    idle_cycles = 0;
  int    send_idle_pct = 33;
  bit    hold_sender = 1'b0;
  bit    stimulus_done = 1'b0;
  int    func_count [4] = '{0, 0, 0, 0};
  int    err_count  [5] = '{0, 0, 0, 0, 0};

  function automatic logic [isq_pkg::IN_KEY_BITS-1:0] slot_key(int s);
    return key_of[slot_idx[s]];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [isq_pkg::IDX_BITS-1:0] ia, ib;
    ia = slot_idx[a];
    ib = slot_idx[b];
    slot_idx[a] = ib;
    slot_idx[b] = ia;
    where_is[ia] = b[isq_pkg::IDX_BITS-1:0];
    where_is[ib] = a[isq_pkg::IDX_BITS-1:0];
  endfunction

  // Strictly-less bubbling toward the front keeps equal keys in arrival order.
  function automatic void sink_front(int s);
    while (s > 0 && slot_key(s) < slot_key(s - 1)) begin
      swap_slots(s, s - 1);
      s--;
    end
  endfunction

  function automatic void reposition(logic [isq_pkg::IDX_BITS-1:0] idx);
    int s;
    sink_front(where_is[idx]);
    s = where_is[idx];
    while (s + 1 < depth && slot_key(s) > slot_key(s + 1)) begin
      swap_slots(s, s + 1);
      s++;
    end
  endfunction

  // Applies one command to the shadow queue and returns the response it must produce.
  function automatic resp_t apply_queue_cmd(cmd_t c);
    resp_t r;
    int s;
    bit here;
    here = in_queue[c.index];
    r = '0;
    r.error_code = isq_pkg::ERR_OK;
    case (c.func)
      isq_pkg::FN_INSERT: begin
        if (here) r.error_code = isq_pkg::ERR_PRESENT;
        else if (depth >= CAPACITY) r.error_code = isq_pkg::ERR_FULL;
        else begin
          key_of[c.index] = c.key;
          slot_idx[depth] = c.index;
          where_is[c.index] = depth[isq_pkg::IDX_BITS-1:0];
          depth++;
          in_queue[c.index] = 1'b1;
          sink_front(depth - 1);
        end
      end
      isq_pkg::FN_POP: begin
        if (depth == 0) r.error_code = isq_pkg::ERR_EMPTY;
        else begin
          depth--;
          r.popped_index = slot_idx[depth];
          r.popped_valid = 1'b1;
          in_queue[r.popped_index] = 1'b0;
        end
      end
      isq_pkg::FN_CHANGE: begin
        if (!here) r.error_code = isq_pkg::ERR_ABSENT;
        else begin
          key_of[c.index] = c.key;
          reposition(c.index);
        end
      end
      default: begin
        if (!here) r.error_code = isq_pkg::ERR_ABSENT;
        else begin
          s = where_is[c.index];
          depth--;
          swap_slots(s, depth);
          in_queue[c.index] = 1'b0;
          if (s < depth) reposition(slot_idx[s]);
        end
      end
    endcase
    r.queue_count = depth[isq_pkg::CNT_BITS-1:0];
    r.queue_empty = (depth == 0);
    return r;
  endfunction

  // Driver: start stays high across back-to-back transactions, one assignment per edge.
  always @(posedge clk) begin
    cmd_t c;
    if (rst_n) begin
      if (start && !busy) begin
        c.func = in_func;
        c.index = in_item_index;
        c.key = in_item_key;
        expected_resps.push_back(apply_queue_cmd(c));
        func_count[c.func]++;
        void'(pending_cmds.pop_front());
      end
      if ((start && !busy) || !start) begin
        if (pending_cmds.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds[0];
          start <= 1'b1;
          in_func <= c.func;
          in_item_index <= c.index;
          in_item_key <= c.key;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed response is checked against the oldest prediction.
  always @(posedge clk) begin
    resp_t got, want;
    if (rst_n && out_strobe) begin
      got.popped_index = out_popped_index;
      got.popped_valid = out_popped_valid;
      got.queue_count = out_queue_count;
      got.queue_empty = out_queue_empty;
      got.error_code = out_error_code;
      responses_seen++;
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
      end else begin
        want = expected_resps.pop_front();
        if (want.error_code <= isq_pkg::ERR_PRESENT) err_count[want.error_code]++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("response mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("indexed_sorted_priority_queue_tb NOT OK");
      $finish;
    end
  end

  function automatic void add_cmd(logic [1:0] f, int idx, int key);
    cmd_t c;
    c.func = f;
    c.index = idx[isq_pkg::IDX_BITS-1:0];
    c.key = key[isq_pkg::IN_KEY_BITS-1:0];
    pending_cmds.push_back(c);
  endfunction

  // Random traffic biased toward a queue that moves in and out of full and empty.
  // Deletes and changes pick indices uniformly, so they may name absent indices.
  task automatic random_traffic(int n);
    int fill, roll;
    logic [1:0] f;
    fill = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) fill = $urandom_range(2);
      roll = $urandom_range(99);
      if (fill == 0) f = (roll < 60) ? isq_pkg::FN_INSERT : (roll < 75) ? isq_pkg::FN_POP
                         : (roll < 88) ? isq_pkg::FN_CHANGE : isq_pkg::FN_DELETE;
      else if (fill == 1) f = (roll < 20) ? isq_pkg::FN_INSERT
                              : (roll < 70) ? isq_pkg::FN_POP
                              : (roll < 85) ? isq_pkg::FN_CHANGE : isq_pkg::FN_DELETE;
      else f = (roll < 35) ? isq_pkg::FN_INSERT : (roll < 55) ? isq_pkg::FN_POP
               : (roll < 80) ? isq_pkg::FN_CHANGE : isq_pkg::FN_DELETE;
      roll = $urandom_range(3);
      // Narrow key ranges produce many ties, which exercise arrival order.
      add_cmd(f, $urandom_range(63),
              roll == 0 ? $urandom_range(3) : roll == 1 ? $urandom_range(65535)
              : roll == 2 ? 65535 - $urandom_range(3) : $urandom_range(40));
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || busy || expected_resps.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty errors, key extremes, ties, absent and present indices.
    add_cmd(isq_pkg::FN_POP, 0, 0);
    add_cmd(isq_pkg::FN_DELETE, 5, 0);
    add_cmd(isq_pkg::FN_CHANGE, 63, 1);
    add_cmd(isq_pkg::FN_INSERT, 0, 65535);
    add_cmd(isq_pkg::FN_INSERT, 63, 0);
    add_cmd(isq_pkg::FN_INSERT, 21, 32768);
    add_cmd(isq_pkg::FN_INSERT, 42, 32768);
    add_cmd(isq_pkg::FN_INSERT, 42, 7);
    add_cmd(isq_pkg::FN_CHANGE, 63, 65535);
    add_cmd(isq_pkg::FN_CHANGE, 0, 0);
    add_cmd(isq_pkg::FN_DELETE, 21, 0);
    add_cmd(isq_pkg::FN_DELETE, 9, 0);
    add_cmd(isq_pkg::FN_POP, 0, 0);
    add_cmd(isq_pkg::FN_POP, 0, 0);
    add_cmd(isq_pkg::FN_POP, 0, 0);
    add_cmd(isq_pkg::FN_POP, 0, 0);
    // Fill to capacity, then one more insert of an index already present hits the present error.
    for (int i = 0; i < CAPACITY; i++) add_cmd(isq_pkg::FN_INSERT, i, (i * 37) % 11);
    add_cmd(isq_pkg::FN_INSERT, 7, 1);
    wait_drained();

    random_traffic(500);
    wait_drained();
    send_idle_pct = 81;
    random_traffic(450);
    wait_drained();
    // Queue commands while the sender is held, then release it.
    hold_sender = 1'b1;
    random_traffic(20);
    repeat (3) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();
    send_idle_pct = 0;
    random_traffic(900);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d inserts, %0d pops, %0d changes, %0d deletes; %0d responses",
             func_count[0], func_count[1], func_count[2], func_count[3], responses_seen);
    $display("errors seen: full %0d, empty %0d, absent %0d, present %0d",
             err_count[1], err_count[2], err_count[3], err_count[4]);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("indexed_sorted_priority_queue_tb OK");
    end else begin
      $display("indexed_sorted_priority_queue_tb NOT OK");
    end
    $finish;
  end
endmodule
